FILE: src/tcle_pkg.sv
// ----------------------------------------------------------------------------
// tcle_pkg: shared types and constants of the text console line editor
// Screen geometry, line buffer size, control characters, command codes and
// the packed result record that leaves the block on the output stream.
// ----------------------------------------------------------------------------
package tcle_pkg;

  // screen and line buffer geometry
  localparam int SCREEN_COLS   = 80;
  localparam int SCREEN_ROWS   = 25;
  localparam int LINE_BUF_SIZE = 128;

  // field widths of the item and result records
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CNT_W  = 8;
  localparam int IDX_W  = 7;
  localparam int LCOL_W = 16;
  localparam int CHR_W  = 8;

  // limits used by the compare logic; the _LIM values are one bit wider than the values
  localparam logic [COL_W:0] COL_LIM = (COL_W+1)'(SCREEN_COLS);
  localparam logic [ROW_W:0] ROW_LIM = (ROW_W+1)'(SCREEN_ROWS);
  localparam logic [CNT_W:0] BUF_LIM = (CNT_W+1)'(LINE_BUF_SIZE);
  localparam logic [COL_W-1:0]  COL_LAST = COL_W'(SCREEN_COLS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [LCOL_W-1:0] LCOL_MAX = '1;

  // control characters
  localparam logic [CHR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHR_W-1:0] CH_EOT       = 8'h04;
  localparam logic [CHR_W-1:0] CH_ERASE     = 8'h00;

  // fill attribute after reset
  localparam logic [7:0] FILL_ATTR_RST = 8'h07;

  typedef enum logic [1:0] {
    CMD_PUT_CHAR = 2'd0,
    CMD_KEY_CHAR = 2'd1,
    CMD_KEY_EOT  = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  // result record, last field in the lowest bits, zero pad on top
  typedef struct packed {
    logic [4:0]        pad;
    logic [CNT_W-1:0]  line_count;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CHR_W-1:0]  store_byte;
    logic [IDX_W-1:0]  store_index;
    logic              store_valid;
    logic              screen_clear;
    logic              scroll_up;
    logic [CHR_W-1:0]  cell_char;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;
    logic              cell_write;
  } res_t;

endpackage

FILE: src/tcle_step.sv
// ----------------------------------------------------------------------------
// tcle_step: console state and single-pass update
// Holds cursor, logical column and buffer fill count; computes the result
// of one item and commits the new state when the item advances.
// ----------------------------------------------------------------------------
module tcle_step
  import tcle_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  cmd_t             cmd,
  input  logic [CHR_W-1:0] chr,
  output res_t             res
);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [LCOL_W-1:0] lcol_r, lcol_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic             do_put;
  logic             do_store;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic [CNT_W:0]   cnt_inc;
  logic [COL_W-1:0] col_adv;
  logic [ROW_W-1:0] row_adv;
  logic             wrap;

  assign col_inc = {1'b0, col_r} + (COL_W+1)'(1);
  assign row_inc = {1'b0, row_r} + (ROW_W+1)'(1);
  assign cnt_inc = {1'b0, cnt_r} + (CNT_W+1)'(1);

  // command decode and buffer store
  always_comb begin
    do_put   = 1'b0;
    do_store = 1'b0;
    case (cmd)
      CMD_PUT_CHAR: begin
        do_put = 1'b1;
      end
      CMD_KEY_CHAR: begin
        if (chr == CH_BACKSPACE && cnt_r != '0 && lcol_r != '0) begin
          do_put = 1'b1;
        end else if ((chr != CH_BACKSPACE && cnt_inc < BUF_LIM) ||
                     (chr == CH_NEWLINE && {1'b0, cnt_r} < BUF_LIM)) begin
          do_put   = 1'b1;
          do_store = 1'b1;
        end
      end
      CMD_KEY_EOT: begin
        do_store = ({1'b0, cnt_r} < BUF_LIM);
      end
      default: begin
      end
    endcase
  end

  // cursor advance after a printable character
  always_comb begin
    wrap    = (col_inc >= COL_LIM);
    col_adv = wrap ? '0 : col_inc[COL_W-1:0];
    row_adv = row_r;
    if (wrap) begin
      row_adv = (row_inc >= ROW_LIM) ? ROW_LAST : row_inc[ROW_W-1:0];
    end
  end

  // next state and result
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    lcol_nxt = lcol_r;
    cnt_nxt  = cnt_r;
    res      = '0;

    if (cmd == CMD_CLEAR) begin
      res.screen_clear = 1'b1;
      col_nxt  = '0;
      row_nxt  = '0;
      lcol_nxt = '0;
      cnt_nxt  = '0;
    end

    // buffer: keyboard backspace removes, store appends
    if (cmd == CMD_KEY_CHAR && chr == CH_BACKSPACE && do_put) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (do_store) begin
      res.store_valid = 1'b1;
      res.store_index = cnt_r[IDX_W-1:0];
      res.store_byte  = (cmd == CMD_KEY_EOT) ? CH_EOT : chr;
      cnt_nxt         = cnt_inc[CNT_W-1:0];
    end

    // screen side of one character
    if (do_put) begin
      if (chr == CH_NEWLINE) begin
        lcol_nxt = '0;
        col_nxt  = '0;
        if (row_inc >= ROW_LIM) begin
          res.scroll_up = 1'b1;
          row_nxt = ROW_LAST;
        end else begin
          row_nxt = row_inc[ROW_W-1:0];
        end
      end else if (chr == CH_RETURN) begin
        lcol_nxt = '0;
        col_nxt  = '0;
      end else if (chr == CH_BACKSPACE) begin
        if (lcol_r != '0 && !(col_r == '0 && row_r == '0)) begin
          lcol_nxt = lcol_r - LCOL_W'(1);
          if (col_r == '0) begin
            row_nxt = row_r - ROW_W'(1);
            col_nxt = COL_LAST;
          end else begin
            col_nxt = col_r - COL_W'(1);
          end
          res.cell_write = 1'b1;
          res.cell_col   = col_nxt;
          res.cell_row   = row_nxt;
          res.cell_char  = CH_ERASE;
        end
      end else begin
        res.cell_write = 1'b1;
        res.cell_col   = col_r;
        res.cell_row   = row_r;
        res.cell_char  = chr;
        if (lcol_r != LCOL_MAX) begin
          lcol_nxt = lcol_r + LCOL_W'(1);
        end
        col_nxt = col_adv;
        row_nxt = row_adv;
        res.scroll_up = wrap && (row_inc >= ROW_LIM);
      end
    end

    res.cursor_col = col_nxt;
    res.cursor_row = row_nxt;
    res.line_count = cnt_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      lcol_r <= '0;
      cnt_r  <= '0;
    end else if (adv) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      lcol_r <= lcol_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

FILE: src/text_console_line_editor.sv
// ----------------------------------------------------------------------------
// text_console_line_editor: text-mode console cursor and line discipline
// Input register, single-pass state update and output register.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the in_ stream: in_tuser carries the command, in_tdata the
//   character byte. Each item gives exactly one result on the out_ stream,
//   a packed record of one cell write, scroll and clear flags, one line
//   buffer store and the cursor and fill count after the item.
//   An accepted item waits in the input register and is updated into the
//   output register, which raises out_tvalid, once that register is free or
//   draining.
//   Throughput is one item per cycle while out_tready is high; the cursor and
//   count registers close their update loop through combinational logic only.
//   When the receiver stalls, the result waits in the output register and
//   one more item waits in the input register; in_tready then drops.
//   Reset (rst_n low, synchronous) homes the cursor, empties the line count,
//   drops both registers and sets the fill attribute to 7. The user must
//   write the attribute through cfg_wr_en/cfg_wr_data only while the block
//   is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module text_console_line_editor
  import tcle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic [1:0]  in_tuser,   // [1:0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] cell_write, [7:1] cell_col, [12:8] cell_row, [20:13] cell_char,
  // [21] scroll_up, [22] screen_clear, [23] store_valid, [30:24] store_index,
  // [38:31] store_byte, [45:39] cursor_col, [50:46] cursor_row,
  // [58:51] line_count, [63:59] zero
  output logic [63:0] out_tdata,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic             in_vld_r;
  cmd_t             in_cmd_r;
  logic [CHR_W-1:0] in_chr_r;
  logic             out_vld_r;
  res_t             out_r;
  res_t             res;
  logic [7:0]       fill_attr_r;
  logic             adv;

  // the staged item moves on when the output register is free or draining
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r <= cmd_t'(in_tuser);
      in_chr_r <= in_tdata;
    end
  end

  // state update
  tcle_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .cmd   (in_cmd_r),
    .chr   (in_chr_r),
    .res   (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  // fill attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_attr_r <= FILL_ATTR_RST;
    end else if (cfg_wr_en) begin
      fill_attr_r <= cfg_wr_data;
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> {1'b0, out_r.line_count} <= BUF_LIM)
    else $error("line count beyond buffer size");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ({1'b0, out_r.cursor_col} < COL_LIM &&
                   {1'b0, out_r.cursor_row} < ROW_LIM))
    else $error("cursor off screen");

  a_store_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.store_valid |->
      out_r.line_count == {1'b0, out_r.store_index} + CNT_W'(1))
    else $error("store slot does not match fill count");

  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.screen_clear |->
      (out_r.cursor_col == '0 && out_r.cursor_row == '0 && out_r.line_count == '0))
    else $error("clear did not home cursor and count");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_vld_r && out_vld_r && !out_tready))
    else $error("input stalled without a full pipeline");

  a_attr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cfg_wr_en) && $past(rst_n) |-> $stable(fill_attr_r))
    else $error("fill attribute changed without a write");

endmodule
